// ===== rtl/rgbpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbpwm_pkg: shared types and constants for the rgb pwm packet node
// holds the node state record, the result record and packet index codes
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpwm_pkg;

   localparam logic [7:0] PWM_WRAP = 8'd255;

   // led_levels bit positions
   localparam int LED_RED   = 0;
   localparam int LED_GREEN = 1;
   localparam int LED_BLUE  = 2;

   // byte index codes within a packet
   localparam logic [7:0] IDX_LENGTH = 8'd0;
   localparam logic [7:0] IDX_RED    = 8'd1;
   localparam logic [7:0] IDX_GREEN  = 8'd2;
   localparam logic [7:0] IDX_BLUE   = 8'd3;
   localparam logic [7:0] IDX_FWD    = 8'd4;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   typedef struct packed {
      logic [7:0] pwm_count;
      logic [7:0] duty_red;
      logic [7:0] duty_green;
      logic [7:0] duty_blue;
      logic [2:0] led_levels;
      logic [7:0] byte_index;
      logic [7:0] packet_length;
      logic       busy_flag;
   } state_type;

   typedef struct packed {
      logic       red_on;
      logic       green_on;
      logic       blue_on;
      logic       busy_led;
      logic       tx_valid;
      logic [7:0] tx_byte;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/rgbpwm_step.sv =====
// ----------------------------------------------------------------------------
// rgbpwm_step: next state and result for one beat
// pwm tick update or packet byte update, purely combinational
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpwm_step
   import rgbpwm_pkg::*;
(
   input  wire logic       kind,
   input  wire logic [7:0] rx_byte,
   input  wire state_type  cur,
   output state_type       nxt,
   output result_type      res
);

   logic [7:0] count_base;
   logic [2:0] lv_wrap;
   logic       fwd;

   always_comb begin
      nxt        = cur;
      fwd        = 1'b0;
      count_base = cur.pwm_count;
      lv_wrap    = cur.led_levels;
      if (kind == KIND_TICK) begin
         // wrap: nonzero duties switch on, count restarts
         if (cur.pwm_count == PWM_WRAP) begin
            count_base = '0;
            if (cur.duty_red   != '0) lv_wrap[LED_RED]   = 1'b1;
            if (cur.duty_green != '0) lv_wrap[LED_GREEN] = 1'b1;
            if (cur.duty_blue  != '0) lv_wrap[LED_BLUE]  = 1'b1;
         end
         nxt.led_levels = lv_wrap;
         if (count_base == cur.duty_red)   nxt.led_levels[LED_RED]   = 1'b0;
         if (count_base == cur.duty_green) nxt.led_levels[LED_GREEN] = 1'b0;
         if (count_base == cur.duty_blue)  nxt.led_levels[LED_BLUE]  = 1'b0;
         nxt.pwm_count = count_base + 8'd1;
      end else begin
         if (cur.byte_index == IDX_LENGTH) begin
            nxt.busy_flag     = 1'b1;
            nxt.packet_length = rx_byte;
            nxt.byte_index    = IDX_RED;
         end else if (cur.byte_index < IDX_FWD) begin
            case (cur.byte_index)
               IDX_RED:   nxt.duty_red   = rx_byte;
               IDX_GREEN: nxt.duty_green = rx_byte;
               default:   nxt.duty_blue  = rx_byte;
            endcase
            nxt.byte_index = cur.byte_index + 8'd1;
         end else if (cur.byte_index < cur.packet_length) begin
            fwd            = 1'b1;
            nxt.byte_index = cur.byte_index + 8'd1;
         end else begin
            nxt.byte_index = IDX_LENGTH;
            nxt.busy_flag  = 1'b0;
         end
      end
      res.red_on   = nxt.led_levels[LED_RED];
      res.green_on = nxt.led_levels[LED_GREEN];
      res.blue_on  = nxt.led_levels[LED_BLUE];
      res.busy_led = nxt.busy_flag;
      res.tx_valid = fwd;
      res.tx_byte  = fwd ? rx_byte : 8'd0;
   end

endmodule

`default_nettype wire

// ===== rtl/rgb_pwm_packet_node.sv =====
// ----------------------------------------------------------------------------
// rgb_pwm_packet_node: daisy-chain rgb led node with 8-bit pwm
// packet decoder plus three-channel pwm, one result beat per request beat
// ----------------------------------------------------------------------------
// Each request beat is a pwm tick (kind 0) or a received uart byte (kind 1)
// and yields exactly one response beat carrying the led levels, the busy
// indicator and an optional forwarded transmit byte. Byte 0 of a packet is
// its length, bytes 1 to 3 the red, green and blue duties, further bytes
// below the length are forwarded, and the byte that reaches the length
// closes the packet. A beat is taken in every cycle while req_stall is low: the
// state update is a single pass of compare and increment logic between the state
// registers and the response or skid register. A two-entry output (response
// register plus skid register) lets a new beat in while a finished response is
// still stalled; req_stall rises only once both entries are full.
`default_nettype none

module rgb_pwm_packet_node
   import rgbpwm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_red_on,
   output logic            rsp_green_on,
   output logic            rsp_blue_on,
   output logic            rsp_busy_led,
   output logic            rsp_tx_valid,
   output logic [7:0]      rsp_tx_byte
);

   state_type  state_ff, state_in;
   result_type step_res;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       req_acc, rsp_take;

   // stall only when both output entries hold a beat
   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   rgbpwm_step u_step (
      .kind    (req_kind),
      .rx_byte (req_rx_byte),
      .cur     (state_ff),
      .nxt     (state_in),
      .res     (step_res)
   );

   // output register and skid steering
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_res;
            out_valid_in = req_acc;
         end
      end else if (req_acc) begin
         skid_in       = step_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_red_on   = out_ff.red_on;
   assign rsp_green_on = out_ff.green_on;
   assign rsp_blue_on  = out_ff.blue_on;
   assign rsp_busy_led = out_ff.busy_led;
   assign rsp_tx_valid = out_ff.tx_valid;
   assign rsp_tx_byte  = out_ff.tx_byte;

   // skid entry is only ever filled behind a held response
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while response register is empty");

   // forwarded byte is zero when nothing is forwarded
   a_tx_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_tx_valid) |-> (rsp_tx_byte == 8'd0))
      else $error("tx byte nonzero without tx valid");

   // a tick leaves the packet state alone
   a_tick_keeps_packet : assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_kind == KIND_TICK) |=>
         ($stable(state_ff.busy_flag) && $stable(state_ff.byte_index)))
      else $error("pwm tick changed packet state");

   // a byte leaves the pwm state alone
   a_byte_keeps_pwm : assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_kind == KIND_BYTE) |=>
         ($stable(state_ff.pwm_count) && $stable(state_ff.led_levels)))
      else $error("uart byte changed pwm state");

endmodule

`default_nettype wire

// ===== verif/rgb_pwm_packet_node_test.sv =====
// ----------------------------------------------------------------------------
// rgb_pwm_packet_node_test: self-checking bench for the rgb pwm packet node
// streams pwm ticks and uart packet bytes through the block, predicts every
// response beat from a local copy of the node state and compares per field
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pwm_packet_node_test;
   import rgbpwm_pkg::*;

   localparam int QUIET_LIMIT = 2000;   // cycles with no beat moving on either side
   localparam int HOLD_CYCLES = 60;     // long receiver hold-off
   localparam int PHASE_ITEMS = 60;     // minimum random beats queued per phase

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } node_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_kind = KIND_TICK;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_red_on;
   logic       rsp_green_on;
   logic       rsp_blue_on;
   logic       rsp_busy_led;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;

   rgb_pwm_packet_node DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_red_on   (rsp_red_on),
      .rsp_green_on (rsp_green_on),
      .rsp_blue_on  (rsp_blue_on),
      .rsp_busy_led (rsp_busy_led),
      .rsp_tx_valid (rsp_tx_valid),
      .rsp_tx_byte  (rsp_tx_byte)
   );

   always #4 clock = ~clock;

   // beats waiting to be offered, and responses waiting to be seen
   node_item_type beats_to_send[$];
   result_type    node_outputs_due[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_want      = 1'b0;
   int mismatches     = 0;
   int beats_queued   = 0;

   // ------------------------------------------------------------------------
   // local copy of the node state
   // ------------------------------------------------------------------------
   logic [7:0] pwm_count     = 8'd0;
   logic [7:0] duty [3]      = '{8'd0, 8'd0, 8'd0};
   logic [2:0] led_levels    = 3'b000;
   logic [7:0] byte_idx      = IDX_LENGTH;
   logic [7:0] pkt_len       = 8'd0;
   logic       busy_flag     = 1'b0;

   // advance the node by one accepted beat and queue the response it gives
   function automatic void step_led_node(input logic kind, input logic [7:0] b);
      result_type r;
      r = '0;
      if (kind == KIND_BYTE) begin
         if (byte_idx == IDX_LENGTH) begin
            // length byte opens a packet
            busy_flag = 1'b1;
            pkt_len   = b;
            byte_idx  = IDX_RED;
         end else if (byte_idx < IDX_FWD) begin
            // duty bytes land whatever the length says
            case (byte_idx)
               IDX_RED:   duty[LED_RED]   = b;
               IDX_GREEN: duty[LED_GREEN] = b;
               default:   duty[LED_BLUE]  = b;
            endcase
            byte_idx = byte_idx + 8'd1;
         end else if (byte_idx < pkt_len) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = b;
            byte_idx   = byte_idx + 8'd1;
         end else begin
            // closing byte is swallowed
            byte_idx  = IDX_LENGTH;
            busy_flag = 1'b0;
         end
      end else begin
         if (pwm_count == PWM_WRAP) begin
            for (int ch = 0; ch < 3; ch++) begin
               if (duty[ch] != 8'd0) led_levels[ch] = 1'b1;
            end
            pwm_count = 8'd0;
         end
         // turn-off compare, after any wrap so count 255 never matches
         for (int ch = 0; ch < 3; ch++) begin
            if (pwm_count == duty[ch]) led_levels[ch] = 1'b0;
         end
         pwm_count = pwm_count + 8'd1;
      end
      r.red_on   = led_levels[LED_RED];
      r.green_on = led_levels[LED_GREEN];
      r.blue_on  = led_levels[LED_BLUE];
      r.busy_led = busy_flag;
      node_outputs_due.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // driver: offers queued beats, holds the payload while stalled
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      node_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_led_node(req_kind, req_rx_byte);
         end
         if (!req_valid || !req_stall) begin
            if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt         = beats_to_send.pop_front();
               req_valid   <= 1'b1;
               req_kind    <= nxt.kind;
               req_rx_byte <= nxt.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks each response beat, drives the receiver stall
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      result_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (node_outputs_due.size() == 0) begin
               $display("%0t: response beat with nothing expected", $time);
               mismatches++;
            end else begin
               exp_r = node_outputs_due.pop_front();
               check_field("red_on",   8'(exp_r.red_on),   8'(rsp_red_on));
               check_field("green_on", 8'(exp_r.green_on), 8'(rsp_green_on));
               check_field("blue_on",  8'(exp_r.blue_on),  8'(rsp_blue_on));
               check_field("busy_led", 8'(exp_r.busy_led), 8'(rsp_busy_led));
               check_field("tx_valid", 8'(exp_r.tx_valid), 8'(rsp_tx_valid));
               check_field("tx_byte",  exp_r.tx_byte,      rsp_tx_byte);
            end
         end
         // long hold-off lets the block fill up and push back on its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_want && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: ends the run when no beat moves for too long
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic add_beat(input logic kind, input logic [7:0] b);
      node_item_type it;
      it.kind    = kind;
      it.rx_byte = b;
      beats_to_send.push_back(it);
      beats_queued++;
   endtask

   task automatic add_ticks(input int n);
      for (int i = 0; i < n; i++) add_beat(KIND_TICK, 8'($urandom));
   endtask

   // well-formed packet: length, three duties, forwarded bytes, closing byte
   task automatic add_packet(input logic [7:0] len);
      logic [7:0] d;
      add_beat(KIND_BYTE, len);
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(4))
            0:       d = 8'd0;
            1:       d = 8'd255;
            2:       d = 8'($urandom_range(1, 16));
            default: d = 8'($urandom);
         endcase
         add_beat(KIND_BYTE, d);
      end
      for (int i = 4; i < len; i++) add_beat(KIND_BYTE, 8'($urandom));
      add_beat(KIND_BYTE, 8'($urandom));
   endtask

   task automatic wait_drained;
      while (beats_to_send.size() > 0 || req_valid || node_outputs_due.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int sel;
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero duty at count 0, length zero, full and zero duty,
      // forwarding of 0xff and 0x00, short packet closing at byte 5
      add_beat(KIND_TICK, 8'hff);
      add_beat(KIND_BYTE, 8'd0);
      add_beat(KIND_BYTE, 8'd255);
      add_beat(KIND_BYTE, 8'd0);
      add_beat(KIND_BYTE, 8'd1);
      add_beat(KIND_BYTE, 8'haa);
      add_ticks(3);
      add_beat(KIND_BYTE, 8'd6);
      add_beat(KIND_BYTE, 8'd2);
      add_beat(KIND_BYTE, 8'd255);
      add_beat(KIND_BYTE, 8'd0);
      add_beat(KIND_BYTE, 8'hff);
      add_beat(KIND_BYTE, 8'h00);
      add_beat(KIND_BYTE, 8'h55);
      add_beat(KIND_BYTE, 8'd5);
      add_beat(KIND_BYTE, 8'd128);
      add_beat(KIND_BYTE, 8'd1);
      add_beat(KIND_BYTE, 8'd254);
      add_beat(KIND_BYTE, 8'h80);
      add_beat(KIND_BYTE, 8'h01);
      wait_drained();

      // phases: no idling, sender idle, receiver stalling, both
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = (p == 1) ? 46 : (p == 3) ? 11 : 0;
         recv_stall_pct = (p == 2) ? 46 : (p == 3) ? 11 : 0;
         if (p == 0) hold_want = 1'b1;
         target = beats_queued + PHASE_ITEMS;
         while (beats_queued < target) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
               // tick bursts, now and then long enough to pass a wrap
               if ($urandom_range(7) == 0) add_ticks($urandom_range(200, 300));
               else add_ticks($urandom_range(1, 40));
            end else if (sel < 85) begin
               sel = $urandom_range(99);
               if (sel < 10)      add_packet(8'($urandom_range(0, 3)));
               else if (sel < 97) add_packet(8'($urandom_range(4, 12)));
               else               add_packet(8'($urandom_range(13, 255)));
            end else if (sel < 93) begin
               // broken packet: header and up to four bytes, often with no proper end
               add_beat(KIND_BYTE, 8'($urandom_range(0, 12)));
               repeat ($urandom_range(0, 4)) add_beat(KIND_BYTE, 8'($urandom));
            end else begin
               add_beat(KIND_BYTE, 8'($urandom));
            end
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && node_outputs_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
